### rtl/slw_pkg.sv
// Package with shared constants and types of the sliding window lane search block.
package slw_pkg;
    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int MAX_WINDOWS = 64;
    localparam int XW          = $clog2(MAX_WIDTH);
    localparam int YW          = $clog2(MAX_HEIGHT);
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int FRAME_AW    = XW + YW;
    localparam int CNT_W       = 9;
    localparam int CNT_MAX     = 511;
    localparam int DIV_NW      = 27;
    localparam int DIV_DW      = 18;
    localparam int DIV_CW      = $clog2(DIV_NW + 1);

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_NWIN   = 3'd2;
    localparam logic [2:0] CFG_MARGIN = 3'd3;
    localparam logic [2:0] CFG_MINPIX = 3'd4;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_FETCH = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    typedef struct packed {
        logic                start;
        logic [DIV_NW-1:0]   dividend;
        logic [DIV_DW-1:0]   divisor;
    } t_div_req;
endpackage

### rtl/slw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module slw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/slw_div.sv
// Restoring divider that produces one quotient bit per cycle.
module slw_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  slw_pkg::t_div_req         i_req,
    output logic                      o_done,
    output logic [slw_pkg::DIV_NW-1:0] o_quotient
);
    import slw_pkg::*;

    logic              r_busy, r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem, r_dvs;
    logic [DIV_DW:0]   w_shift, w_trial;

    assign w_shift = {r_rem, r_quo[DIV_NW-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_trial[DIV_DW]) begin
                    r_rem <= w_trial[DIV_DW-1:0];
                    r_quo <= {r_quo[DIV_NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[DIV_DW-1:0];
                    r_quo <= {r_quo[DIV_NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without a run");
endmodule

### rtl/sliding_window_lane_search.sv
// Sliding window lane pixel search: frame store, column histogram and window scan.
// Users: after reset the block clears its column histogram and accepts no
// item meanwhile. A pixel load whose set pixel falls in the lower half also
// passes a histogram read-modify-write state, and the first pixel of a frame
// starts a histogram clear. A search start walks the chosen half of the
// histogram column by column (address state, then data state), then scans for
// the first point. A fetch scans the frame store pixel by pixel (registered
// memory read, then test), with extra states per row and per window. Every
// search start, and every fetch while a search is active, first runs the window
// height division, and each window that recenters runs one more division in the
// shared serial divider. Results sit in an output register.
module sliding_window_lane_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // pixel_set, search_right, zero fill
    input  logic [1:0]  i_s_axis_tuser,   // mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // point_x, point_y, window_index,
                                          // window_center, point_valid, zero fill
    output logic        o_m_axis_tlast    // last
);
    import slw_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LDW   = 4'd2;
    localparam logic [3:0] S_MXA   = 4'd3;
    localparam logic [3:0] S_MXD   = 4'd4;
    localparam logic [3:0] S_HDIV  = 4'd5;
    localparam logic [3:0] S_DIVW  = 4'd6;
    localparam logic [3:0] S_BOUND = 4'd7;
    localparam logic [3:0] S_ROW   = 4'd8;
    localparam logic [3:0] S_COL   = 4'd9;
    localparam logic [3:0] S_DATA  = 4'd10;
    localparam logic [3:0] S_REC   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [9:0]  r_cfg_w, r_cfg_h;
    logic [6:0]  r_cfg_nw;
    logic [7:0]  r_cfg_m;
    logic [15:0] r_cfg_min;

    logic [3:0]  r_state;
    logic [XW:0] r_clr_idx;
    logic        r_clr_inc;
    logic [9:0]  r_ld_col, r_ld_row;
    logic [XW-1:0] r_ld_c;
    logic [8:0]  r_center;
    logic [6:0]  r_win;
    logic [9:0]  r_row, r_col;
    logic [17:0] r_cnt;
    logic [26:0] r_sum;
    logic        r_active, r_enter, r_fetch, r_div_h;
    logic [9:0]  r_wh, r_yhi, r_xlo, r_xhi;
    logic [9:0]  r_mx_addr, r_mx_lo, r_mx_hi, r_best;
    logic [8:0]  r_best_val;
    logic [8:0]  r_pt_x, r_pt_y, r_pt_c;
    logic [5:0]  r_pt_w;
    logic        r_pt_v, r_pt_last;
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic        r_out_last;

    // Effective register values.
    logic [9:0] w_w, w_h;
    logic [6:0] w_nw;
    assign w_w  = (r_cfg_w < 10'd2) ? 10'd2
                : ((r_cfg_w > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : r_cfg_w);
    assign w_h  = (r_cfg_h < 10'd1) ? 10'd1
                : ((r_cfg_h > 10'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : r_cfg_h);
    assign w_nw = (r_cfg_nw < 7'd1) ? 7'd1 : ((r_cfg_nw > 7'd64) ? 7'd64 : r_cfg_nw);

    // Load position with wrap, and the position after it.
    logic [9:0] w_lc, w_lr, w_lc1, w_lr1, w_lr1p;
    always_comb begin
        w_lc = r_ld_col;
        w_lr = r_ld_row;
        if (r_ld_col >= w_w) begin
            w_lc = '0;
            w_lr = r_ld_row + 10'd1;
        end
        if (w_lr >= w_h) begin
            w_lr = '0;
        end
        w_lc1  = w_lc + 10'd1;
        w_lr1  = w_lr;
        w_lr1p = w_lr + 10'd1;
        if (w_lc1 >= w_w) begin
            w_lc1 = '0;
            w_lr1 = (w_lr1p >= w_h) ? 10'd0 : w_lr1p;
        end
    end

    // Window bounds for the current window and center.
    logic [16:0] w_prod;
    logic [9:0]  w_ylo, w_yhi, w_xlo, w_xhi, w_cpm;
    always_comb begin
        w_prod = 17'({10'd0, r_win} + 17'd1) * 17'(r_wh);
        w_ylo  = w_h - w_prod[9:0];
        w_yhi  = w_ylo + r_wh;
        w_cpm  = {1'b0, r_center} + {2'b0, r_cfg_m};
        w_xlo  = ({1'b0, r_center} > {2'b0, r_cfg_m}) ? ({1'b0, r_center} - {2'b0, r_cfg_m})
                                                        : 10'd0;
        w_xhi  = (w_cpm < w_w) ? w_cpm : w_w;
    end

    // Memories and divider.
    logic                f_we, f_wdata, f_rdata;
    logic [FRAME_AW-1:0] f_waddr, f_raddr;
    logic                c_we;
    logic [XW-1:0]       c_waddr, c_raddr;
    logic [CNT_W-1:0]    c_wdata, c_rdata;
    t_div_req            w_div;
    logic                w_div_done;
    logic [DIV_NW-1:0]   w_quo;

    slw_ram #(.WIDTH(1), .DEPTH(FRAME_DEPTH)) u_frame (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata));

    slw_ram #(.WIDTH(CNT_W), .DEPTH(MAX_WIDTH)) u_counts (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata));

    slw_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_div),
        .o_done(w_div_done), .o_quotient(w_quo));

    logic w_acc;
    logic [1:0] w_mode;
    logic w_pix, w_right;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_mode  = i_s_axis_tuser;
    assign w_pix   = i_s_axis_tdata[0];
    assign w_right = i_s_axis_tdata[1];

    always_comb begin
        f_we    = w_acc && (w_mode == MODE_LOAD);
        f_waddr = {w_lr[YW-1:0], w_lc[XW-1:0]};
        f_wdata = w_pix;
        f_raddr = {r_row[YW-1:0], r_col[XW-1:0]};
        c_we    = 1'b0;
        c_waddr = r_clr_idx[XW-1:0];
        c_wdata = (r_clr_idx == '0) ? CNT_W'(r_clr_inc) : '0;
        c_raddr = (r_state == S_IDLE) ? w_lc[XW-1:0] : r_mx_addr[XW-1:0];
        if (r_state == S_CLR) begin
            c_we = 1'b1;
        end else if (r_state == S_LDW) begin
            c_we    = 1'b1;
            c_waddr = r_ld_c;
            c_wdata = (c_rdata == CNT_W'(CNT_MAX)) ? c_rdata : c_rdata + 1'b1;
        end
        w_div.start    = (r_state == S_HDIV) ||
                         ((r_state == S_REC) && (r_cnt > {2'b0, r_cfg_min}) && (r_cnt != '0));
        w_div.dividend = (r_state == S_HDIV) ? {17'd0, w_h} : r_sum;
        w_div.divisor  = (r_state == S_HDIV) ? {11'd0, w_nw} : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= 10'd320;
            r_cfg_h     <= 10'd240;
            r_cfg_nw    <= 7'd15;
            r_cfg_m     <= 8'd32;
            r_cfg_min   <= 16'd15;
            r_state     <= S_CLR;
            r_clr_idx   <= '0;
            r_clr_inc   <= 1'b0;
            r_ld_col    <= '0;
            r_ld_row    <= '0;
            r_center    <= '0;
            r_win       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_active    <= 1'b0;
            r_enter     <= 1'b0;
            r_fetch     <= 1'b0;
            r_div_h     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:  r_cfg_w   <= i_cfg_data[9:0];
                    CFG_HEIGHT: r_cfg_h   <= i_cfg_data[9:0];
                    CFG_NWIN:   r_cfg_nw  <= i_cfg_data[6:0];
                    CFG_MARGIN: r_cfg_m   <= i_cfg_data[7:0];
                    CFG_MINPIX: r_cfg_min <= i_cfg_data;
                    default: ;
                endcase
            end
            // The output state reloads the register itself in the same cycle.
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == (XW+1)'(MAX_WIDTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        case (w_mode)
                            MODE_LOAD: begin
                                r_ld_col <= w_lc1;
                                r_ld_row <= w_lr1;
                                r_ld_c   <= w_lc[XW-1:0];
                                if (w_lr == '0 && w_lc == '0) begin
                                    r_clr_idx <= '0;
                                    r_clr_inc <= w_pix && (w_h[9:1] == '0);
                                    r_state   <= S_CLR;
                                end else if (w_pix && (w_lr >= {1'b0, w_h[9:1]})) begin
                                    r_state <= S_LDW;
                                end
                            end
                            MODE_FETCH: begin
                                r_fetch <= 1'b1;
                                if (!r_active) begin
                                    r_pt_x <= '0; r_pt_y <= '0; r_pt_w <= '0;
                                    r_pt_c <= '0; r_pt_v <= 1'b0; r_pt_last <= 1'b0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_pt_x <= r_col[8:0];
                                    r_pt_y <= r_row[8:0];
                                    r_pt_w <= r_win[5:0];
                                    r_pt_c <= r_center;
                                    r_pt_v <= 1'b1;
                                    r_cnt  <= r_cnt + 1'b1;
                                    r_sum  <= r_sum + {17'd0, r_col};
                                    r_col  <= r_col + 1'b1;
                                    r_state <= S_HDIV;
                                end
                            end
                            MODE_START: begin
                                r_fetch    <= 1'b0;
                                r_mx_lo    <= w_right ? {1'b0, w_w[9:1]} : 10'd0;
                                r_mx_addr  <= w_right ? {1'b0, w_w[9:1]} : 10'd0;
                                r_mx_hi    <= w_right ? w_w : {1'b0, w_w[9:1]};
                                r_state    <= S_MXA;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LDW: r_state <= S_IDLE;
                S_MXA: begin
                    r_state <= (r_mx_addr < r_mx_hi) ? S_MXD : S_HDIV;
                    if (r_mx_addr >= r_mx_hi) begin
                        r_center <= r_best[8:0];
                        r_win    <= '0;
                        r_enter  <= 1'b1;
                    end
                end
                S_MXD: begin
                    if (r_mx_addr == r_mx_lo || c_rdata > r_best_val) begin
                        r_best     <= r_mx_addr;
                        r_best_val <= c_rdata;
                    end
                    r_mx_addr <= r_mx_addr + 1'b1;
                    r_state   <= S_MXA;
                end
                S_HDIV: begin
                    r_div_h <= 1'b1;
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        if (r_div_h) begin
                            r_wh <= w_quo[9:0];
                        end else begin
                            r_center <= w_quo[8:0];
                            r_win    <= r_win + 1'b1;
                            r_enter  <= 1'b1;
                        end
                        r_state <= S_BOUND;
                    end
                end
                S_BOUND: begin
                    if (r_win >= w_nw) begin
                        r_active <= 1'b0;
                        r_pt_last <= 1'b1;
                        r_state  <= r_fetch ? S_OUT : S_IDLE;
                    end else begin
                        r_yhi <= w_yhi; r_xlo <= w_xlo; r_xhi <= w_xhi;
                        if (r_enter) begin
                            r_row <= w_ylo; r_col <= w_xlo;
                            r_cnt <= '0;    r_sum <= '0;
                            r_enter <= 1'b0;
                        end else if (r_row < w_ylo) begin
                            r_row <= w_ylo; r_col <= w_xlo;
                        end
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    if (r_row < r_yhi) begin
                        if (r_col < r_xlo) begin
                            r_col <= r_xlo;
                        end
                        r_state <= S_COL;
                    end else begin
                        r_state <= S_REC;
                    end
                end
                S_COL: begin
                    if (r_col < r_xhi) begin
                        r_state <= S_DATA;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_col   <= r_xlo;
                        r_state <= S_ROW;
                    end
                end
                S_DATA: begin
                    if (f_rdata) begin
                        r_active  <= 1'b1;
                        r_pt_last <= 1'b0;
                        r_state   <= r_fetch ? S_OUT : S_IDLE;
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_state <= S_COL;
                    end
                end
                S_REC: begin
                    if (w_div.start) begin
                        r_div_h <= 1'b0;
                        r_state <= S_DIVW;
                    end else begin
                        r_win   <= r_win + 1'b1;
                        r_enter <= 1'b1;
                        r_state <= S_BOUND;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {6'd0, r_pt_v, r_pt_c, r_pt_w, r_pt_y, r_pt_x};
                        r_out_last  <= r_pt_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    a_active_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_active) |-> (r_win < 7'd64))
        else $error("active search past the last window");
    a_data_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> ($past(r_state) == S_COL))
        else $error("frame store tested without a read");
    a_empty_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[33]) |-> !o_m_axis_tlast)
        else $error("empty result marked last");
endmodule

### tb/sliding_window_lane_search_test.sv
// Testbench for the sliding window lane search block with a self-checking point scoreboard.
`timescale 1ns / 100ps

module sliding_window_lane_search_test;
    import slw_pkg::*;

    typedef struct {
        bit [8:0] x;
        bit [8:0] y;
        bit [5:0] win;
        bit [8:0] center;
        bit       found;
        bit       last;
    } t_lane_point;

    class lane_point_scoreboard;
        // Local mirror of the block state.
        bit          store [FRAME_DEPTH];
        int unsigned col_count [MAX_WIDTH];
        int unsigned regs [5];
        int unsigned load_x, load_y, center, window, scan_x, scan_y, win_pixels;
        longint unsigned win_sum;
        bit          searching;
        t_lane_point expected_points [$];
        int          mismatches;

        function new();
            regs[CFG_WIDTH]  = 320;
            regs[CFG_HEIGHT] = 240;
            regs[CFG_NWIN]   = 15;
            regs[CFG_MARGIN] = 32;
            regs[CFG_MINPIX] = 15;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function int unsigned width_used();
            return clamp(regs[CFG_WIDTH], 2, MAX_WIDTH);
        endfunction

        function int unsigned height_used();
            return clamp(regs[CFG_HEIGHT], 1, MAX_HEIGHT);
        endfunction

        function int unsigned windows_used();
            return clamp(regs[CFG_NWIN], 1, MAX_WINDOWS);
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] value);
            case (idx)
                CFG_WIDTH:  regs[idx] = value[9:0];
                CFG_HEIGHT: regs[idx] = value[9:0];
                CFG_NWIN:   regs[idx] = value[6:0];
                CFG_MARGIN: regs[idx] = value[7:0];
                CFG_MINPIX: regs[idx] = value;
                default: ;
            endcase
        endfunction

        function void bounds(output int unsigned ylo, output int unsigned yhi,
                             output int unsigned xlo, output int unsigned xhi);
            int unsigned h, w, m, wh;
            h   = height_used();
            w   = width_used();
            m   = regs[CFG_MARGIN];
            wh  = h / windows_used();
            ylo = h - (window + 1) * wh;
            yhi = h - window * wh;
            xlo = center > m ? center - m : 0;
            xhi = center + m < w ? center + m : w;
        endfunction

        function void open_window();
            int unsigned ylo, yhi, xlo, xhi;
            bounds(ylo, yhi, xlo, xhi);
            scan_y     = ylo;
            scan_x     = xlo;
            win_pixels = 0;
            win_sum    = 0;
        endfunction

        // Find the next set pixel; a window over the pixel minimum recenters at its end.
        function bit find_next_pixel();
            int unsigned ylo, yhi, xlo, xhi;
            forever begin
                if (window >= windows_used())
                    return 0;
                bounds(ylo, yhi, xlo, xhi);
                if (scan_y < ylo) begin
                    scan_y = ylo;
                    scan_x = xlo;
                end
                while (scan_y < yhi) begin
                    if (scan_x < xlo)
                        scan_x = xlo;
                    while (scan_x < xhi) begin
                        if (store[scan_y * MAX_WIDTH + scan_x])
                            return 1;
                        scan_x++;
                    end
                    scan_y++;
                    scan_x = xlo;
                end
                if (win_pixels > regs[CFG_MINPIX] && win_pixels != 0)
                    center = win_sum / win_pixels;
                window++;
                if (window >= windows_used())
                    return 0;
                open_window();
            end
        endfunction

        function void load_pixel(bit v);
            int unsigned w, h;
            w = width_used();
            h = height_used();
            if (load_x >= w) begin
                load_x = 0;
                load_y++;
            end
            if (load_y >= h)
                load_y = 0;
            if (load_x == 0 && load_y == 0)
                foreach (col_count[i]) col_count[i] = 0;
            store[load_y * MAX_WIDTH + load_x] = v;
            if (v && load_y >= h / 2 && col_count[load_x] < CNT_MAX)
                col_count[load_x]++;
            load_x++;
            if (load_x >= w) begin
                load_x = 0;
                load_y++;
                if (load_y >= h)
                    load_y = 0;
            end
        endfunction

        function void start_search(bit right);
            int unsigned w, lo, hi, best;
            w    = width_used();
            lo   = right ? w / 2 : 0;
            hi   = right ? w : w / 2;
            best = lo;
            for (int unsigned c = lo + 1; c < hi; c++)
                if (col_count[c] > col_count[best])
                    best = c;
            center = best;
            window = 0;
            open_window();
            searching = find_next_pixel();
        endfunction

        // Called for every accepted input item.
        function void note_input(logic [1:0] mode, bit pixel, bit right);
            t_lane_point p;
            p = '{default: 0};
            case (mode)
                MODE_LOAD:  load_pixel(pixel);
                MODE_START: start_search(right);
                MODE_FETCH: begin
                    if (searching) begin
                        p.x      = scan_x;
                        p.y      = scan_y;
                        p.win    = window;
                        p.center = center;
                        p.found  = 1;
                        win_pixels++;
                        win_sum += scan_x;
                        scan_x++;
                        searching = find_next_pixel();
                        p.last   = !searching;
                    end
                    expected_points = {expected_points, p};
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
            mismatches++;
        endtask

        task check_result(logic [39:0] data, logic tlast);
            t_lane_point e;
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
                return;
            end
            e = expected_points.pop_front();
            if (data[8:0] != e.x)      report_mismatch("point_x", data[8:0], e.x);
            if (data[17:9] != e.y)     report_mismatch("point_y", data[17:9], e.y);
            if (data[23:18] != e.win)  report_mismatch("window_index", data[23:18], e.win);
            if (data[32:24] != e.center) report_mismatch("window_center", data[32:24], e.center);
            if (data[33] != e.found)   report_mismatch("point_valid", data[33], e.found);
            if (tlast != e.last)       report_mismatch("last", tlast, e.last);
        endtask
    endclass

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int         STALL_LIMIT  = 300000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // pixel_set, search_right, zero fill
    logic [1:0]  i_s_axis_tuser;   // mode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;   // point_x, point_y, window_index,
                                   // window_center, point_valid, zero fill
    logic        o_m_axis_tlast;

    lane_point_scoreboard points = new();
    bit  no_gaps;
    int  rx_hold;
    int  items_sent;
    int  idle_cycles;

    sliding_window_lane_search DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        i_m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_m_axis_tready = 0;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold = 0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                i_m_axis_tready = 0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready = 1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            points.check_result(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    task write_reg(logic [2:0] idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        points.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task configure(int w, int h, int nwin, int margin, int minpix);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_NWIN, nwin);
        write_reg(CFG_MARGIN, margin);
        write_reg(CFG_MINPIX, minpix);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task send_item(logic [1:0] mode, bit pixel, bit right);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_s_axis_tvalid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1;
        i_s_axis_tuser  = mode;
        i_s_axis_tdata  = {6'd0, right, pixel};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        points.note_input(mode, pixel, right);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stop offering items until every result is in, then let the block settle.
    task wait_idle();
        i_s_axis_tvalid = 0;
        while (points.expected_points.size() != 0) @(negedge i_clk);
        repeat (1100) @(negedge i_clk);
    endtask

    task load_frame(int density);
        int n;
        n = points.width_used() * points.height_used();
        repeat (n) send_item(MODE_LOAD, $urandom_range(0, 99) < density, 0);
    endtask

    // Start a search and fetch points until the search ends or a cap is hit.
    task run_search(bit right, int cap);
        send_item(MODE_START, $urandom_range(0, 1), right);
        for (int k = 0; k < cap && points.searching; k++)
            send_item(MODE_FETCH, $urandom_range(0, 1), $urandom_range(0, 1));
        send_item(MODE_FETCH, 0, 0);
    endtask

    task mixed_traffic(int ops, int density);
        int pick;
        repeat (ops) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                run_search($urandom_range(0, 1), 40);
            else if (pick < 75)
                send_item(MODE_LOAD, $urandom_range(0, 99) < density, $urandom_range(0, 1));
            else if (pick < 85)
                send_item(MODE_FETCH, $urandom_range(0, 1), $urandom_range(0, 1));
            else if (pick < 93)
                send_item(MODE_START, $urandom_range(0, 1), $urandom_range(0, 1));
            else
                send_item(MODE_IGNORED, $urandom_range(0, 1), $urandom_range(0, 1));
        end
        send_item(MODE_FETCH, 0, 0);
    endtask

    initial begin
        int w, h, nwin, margin, minpix, density;
        i_rst_n         = 0;
        i_cfg_we        = 0;
        i_cfg_idx       = CFG_WIDTH;
        i_cfg_data      = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata  = 0;
        i_s_axis_tuser  = MODE_LOAD;
        no_gaps         = 0;
        rx_hold         = 0;
        items_sent      = 0;
        idle_cycles     = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: tiny 4x4 frame, fetch with no search, ignored mode, both halves.
        // The result side backs up for a while during the searches.
        configure(4, 4, 2, 1, 0);
        send_item(MODE_FETCH, 1, 1);
        send_item(MODE_IGNORED, 1, 1);
        for (int i = 0; i < 16; i++)
            send_item(MODE_LOAD, (i % 3) != 1, 0);
        rx_hold = 400;
        run_search(0, 8);
        run_search(1, 8);
        wait_idle();

        // Extremes: widest frame one row tall, registers outside their clamp ranges.
        configure(1023, 0, 0, 255, 0);
        load_frame(30);
        mixed_traffic(6, 30);
        wait_idle();

        // Tallest frame two columns wide, most windows, never recentered.
        configure(1, 1023, 127, 1, 65535);
        no_gaps = 1;
        load_frame(60);
        mixed_traffic(6, 60);
        no_gaps = 0;
        wait_idle();

        // More windows than rows: every window is empty.
        configure(8, 5, 20, 4, 0);
        load_frame(80);
        mixed_traffic(5, 80);
        wait_idle();

        // Random phases; the first one backs the result side up for a while.
        for (int phase = 0; items_sent < 2000; phase++) begin
            w       = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
            h       = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            nwin    = $urandom_range(1, (h > 1 && h < 16) ? h : 16);
            margin  = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 20);
            minpix  = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 8);
            density = $urandom_range(5, 70);
            no_gaps = ($urandom_range(0, 3) == 0);
            configure(w, h, nwin, margin, minpix);
            load_frame(density);
            if (phase == 0)
                rx_hold = 400;
            mixed_traffic($urandom_range(15, 40), density);
            wait_idle();
        end

        if (points.mismatches == 0 && points.expected_points.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
